// ===== rtl/snk_pkg.sv =====
package snk_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int SCORE_W     = 31;
  localparam int RANK_W      = 6;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [RANK_W-1:0]  rank_t;

  localparam idx_t LAST_IDX = idx_t'(TABLE_DEPTH - 1);

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    score_t wdata;
    idx_t   raddr;
  } ram_req_t;

  typedef struct packed {
    logic   load;
    rank_t  rank;
    score_t score;
    logic   accepted;
    logic   last;
  } out_load_t;

endpackage

// ===== rtl/snk_ram.sv =====
module snk_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/snk_seq.sv =====
module snk_seq import snk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  score_t    in_score,
  input  score_t    ram_rdata,
  output ram_req_t  ram_req,
  input  logic      out_free,
  output out_load_t out_load
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]             state_r, state_nxt;
  score_t                 s_r, s_nxt;
  idx_t                   pos_r, pos_nxt;
  logic                   acc_r, acc_nxt;
  idx_t                   k_r, k_nxt;
  logic                   dv_r, dv_nxt;
  logic [TABLE_DEPTH-1:0] vld_r, vld_nxt;
  idx_t                   raddr_r;
  score_t                 rd;
  logic                   advance;

  // entries never written since reset read as zero
  assign rd = vld_r[raddr_r] ? ram_rdata : '0;

  assign in_tready = (state_r == S_IDLE);
  assign advance   = dv_r && out_free;

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    pos_nxt   = pos_r;
    acc_nxt   = acc_r;
    k_nxt     = k_r;
    dv_nxt    = dv_r;
    vld_nxt   = vld_r;
    ram_req   = '{we: 1'b0, waddr: pos_r, wdata: s_r, raddr: k_r};
    out_load  = '{load: 1'b0, rank: rank_t'(k_r), score: rd, accepted: acc_r,
                  last: (k_r == LAST_IDX)};
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          s_nxt         = in_score;
          pos_nxt       = LAST_IDX;
          ram_req.raddr = LAST_IDX;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (s_r <= rd) begin
          acc_nxt   = 1'b0;
          k_nxt     = '0;
          dv_nxt    = 1'b0;
          state_nxt = S_OUT;
        end else begin
          acc_nxt       = 1'b1;
          ram_req.raddr = idx_t'(pos_r - 1'b1);
          state_nxt     = S_CMP;
        end
      end
      S_CMP: begin
        ram_req.we = 1'b1;
        if (rd < s_r) begin
          // shift the smaller entry down one rank
          ram_req.wdata = rd;
          pos_nxt       = idx_t'(pos_r - 1'b1);
          if (pos_r == idx_t'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            ram_req.raddr = idx_t'(pos_r - 2'd2);
          end
        end else begin
          k_nxt     = '0;
          dv_nxt    = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_PLACE: begin
        ram_req.we = 1'b1;
        k_nxt      = '0;
        dv_nxt     = 1'b0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        dv_nxt = 1'b1;
        if (advance) begin
          out_load.load = 1'b1;
          ram_req.raddr = idx_t'(k_r + 1'b1);
          k_nxt         = idx_t'(k_r + 1'b1);
          if (k_r == LAST_IDX) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (ram_req.we) begin
      vld_nxt[ram_req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      dv_r    <= dv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    pos_r   <= pos_nxt;
    acc_r   <= acc_nxt;
    k_r     <= k_nxt;
    raddr_r <= ram_req.raddr;
  end

endmodule

// ===== rtl/top_n_score_keeper.sv =====
// top_n_score_keeper: keeps the TABLE_DEPTH highest scores seen, ranked from
// the highest down, and reports the whole table after every offered score.
// in channel: one request carries one score (in_tdata[30:0]).
// out channel: TABLE_DEPTH requests per offered score, rank 0 first; tdata
// carries rank and score, tuser says whether the score entered the table,
// tlast marks the lowest rank.
// an offered score is compared against the lowest entry, then against each
// higher entry in turn through one comparator and one table memory with separate
// read and write ports, shifting smaller entries down one rank per cycle.
// a rejected score goes from the check straight to the readout; an accepted
// score moves past at most TABLE_DEPTH - 1 entries, landing at rank 0, before
// its readout starts. the readout loads one result per cycle while the output
// register is free. in_tready stays low from acceptance until the last result
// has entered the output register.
// reset: synchronous, active low; the table reads as all zero right away
// (per-entry valid flags), there is no clearing pass.
// when the receiver stalls the output register holds its result and the
// readout simply pauses; no result is dropped.
module top_n_score_keeper import snk_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // new_score[30:0], pad[31]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // entry_rank[5:0], entry_score[36:6], pad[39:37]
  output logic                   out_tuser,  // was_accepted[0]
  output logic                   out_tlast
);

  ram_req_t  ram_req;
  score_t    ram_rdata;
  out_load_t out_load;
  logic      out_free;

  logic      out_valid_r;
  rank_t     rank_r;
  score_t    score_r;
  logic      acc_r;
  logic      last_r;

  assign out_free = !out_valid_r || out_tready;

  snk_ram #(
    .WIDTH(SCORE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  snk_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_score (in_tdata[SCORE_W-1:0]),
    .ram_rdata(ram_rdata),
    .ram_req  (ram_req),
    .out_free (out_free),
    .out_load (out_load)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load.load) begin
      rank_r  <= out_load.rank;
      score_r <= out_load.score;
      acc_r   <= out_load.accepted;
      last_r  <= out_load.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - SCORE_W - RANK_W)'(0), score_r, rank_r};
  assign out_tuser  = acc_r;
  assign out_tlast  = last_r;

endmodule

// ===== rtl/snk_checker.sv =====
module snk_checker import snk_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // input ready is low right after each accepted request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a request");

  // tlast only on the lowest rank
  a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[RANK_W-1:0] == rank_t'(TABLE_DEPTH - 1))))
    else $error("tlast does not match lowest rank");

  // readout runs gap free with consecutive ranks and one accepted flag
  a_next_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tdata[RANK_W-1:0] == rank_t'($past(out_tdata[RANK_W-1:0]) + 1'b1)
      && out_tuser == $past(out_tuser))
    else $error("readout rank sequence broken");

  // ranked order is non-increasing within a run
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tdata[RANK_W+SCORE_W-1:RANK_W] <= $past(out_tdata[RANK_W+SCORE_W-1:RANK_W]))
    else $error("table order broken");

endmodule

bind top_n_score_keeper snk_checker u_chk (.*);
